// ===== hw/rtl/bbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants of the ball bounce step
// Field widths, fixed-point constants, datapath operation codes, controller
// states and the saturation helpers.
// ----------------------------------------------------------------------------
package bbs_pkg;

    localparam int BBS_BALL_RADIUS = 40;

    localparam int FRAC_BITS = 8;
    localparam int DT_W      = 16;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 22;
    localparam int VEL_W     = 19;
    localparam int MASK_W    = 5;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_N     = 8;
    localparam int K_W       = 24;   // 200 * dt
    localparam int ACC_W     = 64;
    localparam int MUL_W     = 34;
    localparam int DIV_NW    = 48;
    localparam int DIV_DW    = 27;
    localparam int SQ_IW     = 38;
    localparam int SQ_RW     = 19;
    localparam int NN_W      = 26;
    localparam int AD_W      = 37;
    localparam int VN_W      = 33;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    // speed commands
    localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;

    // speed limits, squared, in raw Q.8 units
    localparam logic [ACC_W-1:0] MAX_SPEED_SQ = 64'd16384000000;
    localparam logic [ACC_W-1:0] MIN_SPEED_SQ = 64'd6553600;

    // state after reset
    localparam logic [POS_W-1:0] POS_X_RST = 22'd102400;
    localparam logic [POS_W-1:0] POS_Y_RST = 22'd76800;
    localparam logic [VEL_W-1:0] VEL_RST   = 19'd27136;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_LEFT   = 3'd0,
        CFG_AREA_RIGHT  = 3'd1,
        CFG_AREA_BOTTOM = 3'd2,
        CFG_AREA_TOP    = 3'd3,
        CFG_LINE_A_X    = 3'd4,
        CFG_LINE_A_Y    = 3'd5,
        CFG_LINE_B_X    = 3'd6,
        CFG_LINE_B_Y    = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_N] = '{
        12'd50, 12'd750, 12'd50, 12'd550, 12'd200, 12'd100, 12'd600, 12'd150
    };

    typedef enum logic [4:0] {
        OP_NONE, OP_SQX, OP_SQY, OP_SQRT, OP_GETM, OP_KX, OP_KY, OP_DIV_SPD,
        OP_UPD_SX, OP_UPD_SY, OP_ADVMX, OP_ADDX, OP_ADVMY, OP_ADDY,
        OP_NN1, OP_NN2, OP_DS1, OP_DS2, OP_ADSQ, OP_RR, OP_VN1, OP_VN2,
        OP_LX, OP_LY, OP_DIV_LINE, OP_UPD_LX, OP_UPD_LY, OP_WALL
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQRT, ST_SQRT_W, ST_GETM,
        ST_KX, ST_DIVX, ST_DIVX_W, ST_UPDX, ST_KY, ST_DIVY, ST_DIVY_W, ST_UPDY,
        ST_ADVMX, ST_ADDX, ST_ADVMY, ST_ADDY,
        ST_NN1, ST_NN2, ST_DS1, ST_DS2, ST_ADSQ, ST_RR, ST_VN1, ST_VN2,
        ST_LX, ST_LDIVX, ST_LDIVX_W, ST_LUPDX, ST_LY, ST_LDIVY, ST_LDIVY_W, ST_LUPDY,
        ST_WALL
    } t_state;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_dp_cmd;

    typedef struct packed {
        logic spd_go;
        logic m_zero;
        logic line_hit;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // clamp a wide signed value to the velocity range
    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [50:0] v);
        logic [VEL_W-1:0] res;
        if (v > 51'sd262143) begin
            res = 19'h3FFFF;
        end else if (v < -51'sd262144) begin
            res = 19'h40000;
        end else begin
            res = v[VEL_W-1:0];
        end
        return res;
    endfunction

    // clamp to the position range
    function automatic logic [POS_W-1:0] sat_pos(input logic signed [24:0] v);
        logic [POS_W-1:0] res;
        if (v > 25'sd2097151) begin
            res = 22'h1FFFFF;
        end else if (v < -25'sd2097152) begin
            res = 22'h200000;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    // negate a velocity, the most negative value saturates
    function automatic logic [VEL_W-1:0] neg_vel(input logic [VEL_W-1:0] v);
        logic signed [50:0] ext;
        ext = $signed({{32{v[VEL_W-1]}}, v});
        return sat_vel(-ext);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bbs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_div: iterative unsigned divider
// Restoring shift-subtract, one quotient bit per cycle, quotient held after.
// ----------------------------------------------------------------------------
module bbs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bbs_pkg::DIV_NW-1:0] i_num,
    input  wire logic [bbs_pkg::DIV_DW-1:0] i_den,
    output logic                            o_done,
    output logic [bbs_pkg::DIV_NW-1:0]      o_quot
);
    import bbs_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    // trial subtract
    assign rem_sh = {r_rem, r_num[DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the numerator out and the quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], fits};
            r_rem <= fits ? DIV_DW'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
`default_nettype wire

// ===== hw/rtl/bbs_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_sqrt: iterative integer square root
// Digit-by-digit method, one root bit per cycle, root held after.
// ----------------------------------------------------------------------------
module bbs_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [bbs_pkg::SQ_IW-1:0] i_val,
    output logic                           o_done,
    output logic [bbs_pkg::SQ_RW-1:0]      o_root
);
    import bbs_pkg::*;

    localparam int CNT_W = $clog2(SQ_RW);

    logic [SQ_IW-1:0] r_x;
    logic [SQ_IW-1:0] r_r;
    logic [SQ_IW-1:0] r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SQ_IW:0]   trial;
    logic             fits;

    assign trial = {1'b0, r_r} + {1'b0, r_bit};
    assign fits  = {1'b0, r_x} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SQ_RW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one root digit per cycle, starting at the top even bit position
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_val;
            r_r   <= '0;
            r_bit <= SQ_IW'(1) << (2 * (SQ_RW - 1));
        end else if (r_busy) begin
            if (fits) begin
                r_x <= SQ_IW'({1'b0, r_x} - trial);
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_RW-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/bbs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_ctrl: step sequencer
// Walks one tick through speed change, advance, line and walls, issuing at
// most one datapath operation per state.
// ----------------------------------------------------------------------------
module bbs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire bbs_pkg::t_dp_stat i_stat,
    output bbs_pkg::t_dp_cmd       o_cmd
);
    import bbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_SQX;
            ST_SQX:     n_state = ST_SQY;
            ST_SQY:     n_state = ST_SQRT;
            ST_SQRT:    n_state = i_stat.spd_go ? ST_SQRT_W : ST_ADVMX;
            ST_SQRT_W:  if (i_stat.sqrt_done) n_state = ST_GETM;
            ST_GETM:    n_state = i_stat.m_zero ? ST_ADVMX : ST_KX;
            ST_KX:      n_state = ST_DIVX;
            ST_DIVX:    n_state = ST_DIVX_W;
            ST_DIVX_W:  if (i_stat.div_done) n_state = ST_UPDX;
            ST_UPDX:    n_state = ST_KY;
            ST_KY:      n_state = ST_DIVY;
            ST_DIVY:    n_state = ST_DIVY_W;
            ST_DIVY_W:  if (i_stat.div_done) n_state = ST_UPDY;
            ST_UPDY:    n_state = ST_ADVMX;
            ST_ADVMX:   n_state = ST_ADDX;
            ST_ADDX:    n_state = ST_ADVMY;
            ST_ADVMY:   n_state = ST_ADDY;
            ST_ADDY:    n_state = ST_NN1;
            ST_NN1:     n_state = ST_NN2;
            ST_NN2:     n_state = ST_DS1;
            ST_DS1:     n_state = ST_DS2;
            ST_DS2:     n_state = ST_ADSQ;
            ST_ADSQ:    n_state = ST_RR;
            ST_RR:      n_state = ST_VN1;
            ST_VN1:     n_state = ST_VN2;
            ST_VN2:     n_state = ST_LX;
            ST_LX:      n_state = i_stat.line_hit ? ST_LDIVX : ST_WALL;
            ST_LDIVX:   n_state = ST_LDIVX_W;
            ST_LDIVX_W: if (i_stat.div_done) n_state = ST_LUPDX;
            ST_LUPDX:   n_state = ST_LY;
            ST_LY:      n_state = ST_LDIVY;
            ST_LDIVY:   n_state = ST_LDIVY_W;
            ST_LDIVY_W: if (i_stat.div_done) n_state = ST_LUPDY;
            ST_LUPDY:   n_state = ST_WALL;
            ST_WALL:    if (i_stat.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE:    o_cmd.in_ready = 1'b1;
            ST_SQX:     o_cmd.op = OP_SQX;
            ST_SQY:     o_cmd.op = OP_SQY;
            ST_SQRT:    if (i_stat.spd_go) o_cmd.op = OP_SQRT;
            ST_GETM:    o_cmd.op = OP_GETM;
            ST_KX:      o_cmd.op = OP_KX;
            ST_DIVX:    o_cmd.op = OP_DIV_SPD;
            ST_UPDX:    o_cmd.op = OP_UPD_SX;
            ST_KY:      o_cmd.op = OP_KY;
            ST_DIVY:    o_cmd.op = OP_DIV_SPD;
            ST_UPDY:    o_cmd.op = OP_UPD_SY;
            ST_ADVMX:   o_cmd.op = OP_ADVMX;
            ST_ADDX:    o_cmd.op = OP_ADDX;
            ST_ADVMY:   o_cmd.op = OP_ADVMY;
            ST_ADDY:    o_cmd.op = OP_ADDY;
            ST_NN1:     o_cmd.op = OP_NN1;
            ST_NN2:     o_cmd.op = OP_NN2;
            ST_DS1:     o_cmd.op = OP_DS1;
            ST_DS2:     o_cmd.op = OP_DS2;
            ST_ADSQ:    o_cmd.op = OP_ADSQ;
            ST_RR:      o_cmd.op = OP_RR;
            ST_VN1:     o_cmd.op = OP_VN1;
            ST_VN2:     o_cmd.op = OP_VN2;
            ST_LX:      if (i_stat.line_hit) o_cmd.op = OP_LX;
            ST_LDIVX:   o_cmd.op = OP_DIV_LINE;
            ST_LUPDX:   o_cmd.op = OP_UPD_LX;
            ST_LY:      o_cmd.op = OP_LY;
            ST_LDIVY:   o_cmd.op = OP_DIV_LINE;
            ST_LUPDY:   o_cmd.op = OP_UPD_LY;
            ST_WALL:    if (i_stat.out_free) o_cmd.op = OP_WALL;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bbs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_dp: ball step datapath
// Configuration, ball state, one shared multiplier with accumulator, the
// square root and divider units, wall tests and the output register.
// ----------------------------------------------------------------------------
module bbs_dp #(
    parameter int BALL_RADIUS = bbs_pkg::BBS_BALL_RADIUS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bbs_pkg::t_dp_cmd               i_cmd,
    output bbs_pkg::t_dp_stat                   o_stat,
    input  wire logic                           i_cfg_we,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bbs_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic [bbs_pkg::DT_W-1:0]       i_dt,
    input  wire logic [bbs_pkg::CMD_W-1:0]      i_speed_cmd,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [bbs_pkg::POS_W-1:0]           o_ball_x,
    output logic [bbs_pkg::POS_W-1:0]           o_ball_y,
    output logic [bbs_pkg::VEL_W-1:0]           o_vel_x,
    output logic [bbs_pkg::VEL_W-1:0]           o_vel_y,
    output logic [bbs_pkg::MASK_W-1:0]          o_bounce_mask
);
    import bbs_pkg::*;

    localparam int RAD_Q = BALL_RADIUS * (1 << FRAC_BITS);
    localparam logic [MUL_W-1:0] RAD_SQ = MUL_W'(longint'(RAD_Q) * longint'(RAD_Q));
    localparam logic signed [24:0] RAD_W = 25'(RAD_Q);

    // configuration and ball state
    logic [CFG_W-1:0]         r_cfg [CFG_N];
    logic signed [POS_W-1:0]  r_px, r_py;
    logic signed [VEL_W-1:0]  r_vx, r_vy;
    logic [DT_W-1:0]          r_dt;
    logic [CMD_W-1:0]         r_cmd;
    logic [K_W-1:0]           r_k;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SQ_RW-1:0]         r_m;
    logic [NN_W-1:0]          r_nn;
    logic [AD_W-1:0]          r_ad;
    logic [59:0]              r_ad2;
    logic [57:0]              r_rhs;
    logic signed [VN_W-1:0]   r_vn;
    logic                     r_line;
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_o_x, r_o_y;
    logic [VEL_W-1:0]         r_o_vx, r_o_vy;
    logic [MASK_W-1:0]        r_o_mask;

    logic                     in_fire;
    logic signed [12:0]       dx, dy;
    logic signed [23:0]       rel_x, rel_y;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic [1:0]               acc_mode;
    logic signed [ACC_W-1:0]  n_acc;
    logic [ACC_W-1:0]         acc_mag;
    logic                     div_start;
    logic [DIV_DW-1:0]        div_den;
    logic [DIV_NW-1:0]        div_num;
    logic                     div_done;
    logic [DIV_NW-1:0]        div_quot;
    logic signed [50:0]       delta;
    logic signed [50:0]       vx_ext, vy_ext;
    logic                     sqrt_done;
    logic [SQ_RW-1:0]         sqrt_root;
    logic [19:0]              adv_mag;
    logic signed [24:0]       adv_step;
    logic signed [24:0]       px_w, py_w;
    logic                     hit_r, hit_l, hit_t, hit_b;
    logic [VEL_W-1:0]         vx1, vx2, vy1, vy2;

    localparam logic [1:0] ACC_SET = 2'd0;
    localparam logic [1:0] ACC_ADD = 2'd1;
    localparam logic [1:0] ACC_SUB = 2'd2;
    localparam logic [1:0] ACC_OFF = 2'd3;

    assign in_fire = i_in_valid && i_cmd.in_ready;

    // line geometry
    assign dx = $signed({1'b0, r_cfg[CFG_LINE_B_X]}) - $signed({1'b0, r_cfg[CFG_LINE_A_X]});
    assign dy = $signed({1'b0, r_cfg[CFG_LINE_B_Y]}) - $signed({1'b0, r_cfg[CFG_LINE_A_Y]});
    assign rel_x = $signed({{2{r_px[POS_W-1]}}, r_px})
                 - $signed({4'b0, r_cfg[CFG_LINE_A_X], 8'b0});
    assign rel_y = $signed({{2{r_py[POS_W-1]}}, r_py})
                 - $signed({4'b0, r_cfg[CFG_LINE_A_Y], 8'b0});

    // select multiplier operands and accumulate mode
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        acc_mode = ACC_OFF;
        case (i_cmd.op)
            OP_SQX: begin
                mul_a = MUL_W'(r_vx); mul_b = MUL_W'(r_vx); acc_mode = ACC_SET;
            end
            OP_SQY: begin
                mul_a = MUL_W'(r_vy); mul_b = MUL_W'(r_vy); acc_mode = ACC_ADD;
            end
            OP_KX: begin
                mul_a = $signed({10'b0, r_k}); mul_b = MUL_W'(r_vx); acc_mode = ACC_SET;
            end
            OP_KY: begin
                mul_a = $signed({10'b0, r_k}); mul_b = MUL_W'(r_vy); acc_mode = ACC_SET;
            end
            OP_ADVMX: begin
                mul_a = MUL_W'(r_vx); mul_b = $signed({18'b0, r_dt}); acc_mode = ACC_SET;
            end
            OP_ADVMY: begin
                mul_a = MUL_W'(r_vy); mul_b = $signed({18'b0, r_dt}); acc_mode = ACC_SET;
            end
            OP_NN1: begin
                mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); acc_mode = ACC_SET;
            end
            OP_NN2: begin
                mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); acc_mode = ACC_ADD;
            end
            OP_DS1: begin
                mul_a = MUL_W'(rel_x); mul_b = MUL_W'(dy); acc_mode = ACC_SET;
            end
            OP_DS2: begin
                mul_a = MUL_W'(rel_y); mul_b = MUL_W'(dx); acc_mode = ACC_SUB;
            end
            OP_ADSQ: begin
                mul_a = $signed({4'b0, r_ad[29:0]}); mul_b = $signed({4'b0, r_ad[29:0]});
                acc_mode = ACC_SET;
            end
            OP_RR: begin
                mul_a = $signed(RAD_SQ); mul_b = $signed({8'b0, r_nn}); acc_mode = ACC_SET;
            end
            OP_VN1: begin
                mul_a = MUL_W'(r_vx); mul_b = MUL_W'(dy); acc_mode = ACC_SET;
            end
            OP_VN2: begin
                mul_a = MUL_W'(r_vy); mul_b = MUL_W'(dx); acc_mode = ACC_SUB;
            end
            OP_LX: begin
                mul_a = $signed({r_vn, 1'b0}); mul_b = MUL_W'(dy); acc_mode = ACC_SET;
            end
            OP_LY: begin
                mul_a = $signed({r_vn, 1'b0}); mul_b = MUL_W'(dx); acc_mode = ACC_SET;
            end
            default: acc_mode = ACC_OFF;
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        case (acc_mode)
            ACC_ADD: n_acc = r_acc + prod[ACC_W-1:0];
            ACC_SUB: n_acc = r_acc - prod[ACC_W-1:0];
            ACC_SET: n_acc = prod[ACC_W-1:0];
            default: n_acc = r_acc;
        endcase
    end

    // rounded division: magnitude plus half the divisor
    assign acc_mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign div_start = (i_cmd.op == OP_DIV_SPD) || (i_cmd.op == OP_DIV_LINE);
    assign div_den   = (i_cmd.op == OP_DIV_SPD) ? {r_m, 8'b0} : {1'b0, r_nn};
    assign div_num   = acc_mag[DIV_NW-1:0] + DIV_NW'(div_den >> 1);
    assign delta     = r_acc[ACC_W-1] ? -$signed({3'b0, div_quot}) : $signed({3'b0, div_quot});
    assign vx_ext    = 51'(r_vx);
    assign vy_ext    = 51'(r_vy);

    bbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    bbs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_val   (r_acc[SQ_IW-1:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // position step: v*dt/65536 rounded half away from zero
    assign adv_mag  = 20'((acc_mag[35:0] + 36'd32768) >> 16);
    assign adv_step = r_acc[ACC_W-1] ? -$signed({5'b0, adv_mag}) : $signed({5'b0, adv_mag});
    assign px_w     = 25'(r_px);
    assign py_w     = 25'(r_py);

    // walls in order right, left, top, bottom
    always_comb begin
        hit_r = (px_w + RAD_W >= $signed({5'b0, r_cfg[CFG_AREA_RIGHT], 8'b0}))
              && !r_vx[VEL_W-1] && (r_vx != '0);
        vx1   = hit_r ? neg_vel(r_vx) : r_vx;
        hit_l = (px_w - RAD_W <= $signed({5'b0, r_cfg[CFG_AREA_LEFT], 8'b0}))
              && vx1[VEL_W-1];
        vx2   = hit_l ? neg_vel(vx1) : vx1;
        hit_t = (py_w + RAD_W >= $signed({5'b0, r_cfg[CFG_AREA_TOP], 8'b0}))
              && !r_vy[VEL_W-1] && (r_vy != '0);
        vy1   = hit_t ? neg_vel(r_vy) : r_vy;
        hit_b = (py_w - RAD_W <= $signed({5'b0, r_cfg[CFG_AREA_BOTTOM], 8'b0}))
              && vy1[VEL_W-1];
        vy2   = hit_b ? neg_vel(vy1) : vy1;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_N; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ball state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= POS_X_RST;
            r_py <= POS_Y_RST;
            r_vx <= VEL_RST;
            r_vy <= VEL_RST;
        end else begin
            case (i_cmd.op)
                OP_UPD_SX: r_vx <= sat_vel((r_cmd == CMD_UP) ? vx_ext + delta : vx_ext - delta);
                OP_UPD_SY: r_vy <= sat_vel((r_cmd == CMD_UP) ? vy_ext + delta : vy_ext - delta);
                OP_ADDX:   r_px <= sat_pos(px_w + adv_step);
                OP_ADDY:   r_py <= sat_pos(py_w + adv_step);
                OP_UPD_LX: r_vx <= sat_vel(vx_ext - delta);
                OP_UPD_LY: r_vy <= sat_vel(vy_ext + delta);
                OP_WALL: begin
                    r_vx <= vx2;
                    r_vy <= vy2;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dt   <= i_dt;
            r_cmd  <= i_speed_cmd;
            r_k    <= (K_W'(i_dt) << 7) + (K_W'(i_dt) << 6) + (K_W'(i_dt) << 3);
            r_line <= 1'b0;
        end
        r_acc <= n_acc;
        case (i_cmd.op)
            OP_GETM:   r_m   <= sqrt_root;
            OP_NN2:    r_nn  <= n_acc[NN_W-1:0];
            OP_DS2:    r_ad  <= n_acc[ACC_W-1] ? AD_W'(-n_acc) : n_acc[AD_W-1:0];
            OP_ADSQ:   r_ad2 <= n_acc[59:0];
            OP_RR:     r_rhs <= n_acc[57:0];
            OP_VN2:    r_vn  <= n_acc[VN_W-1:0];
            OP_UPD_LX: r_line <= 1'b1;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_WALL) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WALL) begin
            r_o_x    <= r_px;
            r_o_y    <= r_py;
            r_o_vx   <= vx2;
            r_o_vy   <= vy2;
            r_o_mask <= {hit_b, hit_t, hit_l, hit_r, r_line};
        end
    end

    // status to the sequencer
    always_comb begin
        o_stat.spd_go = ((r_cmd == CMD_UP) && ($unsigned(r_acc) < MAX_SPEED_SQ))
                     || ((r_cmd == CMD_DOWN) && ($unsigned(r_acc) > MIN_SPEED_SQ));
        o_stat.m_zero    = (sqrt_root == '0);
        o_stat.line_hit  = (r_nn != '0) && (r_ad[AD_W-1:30] == '0)
                        && (r_ad2 <= 60'(r_rhs)) && r_vn[VN_W-1];
        o_stat.sqrt_done = sqrt_done;
        o_stat.div_done  = div_done;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_ball_x      = r_o_x;
    assign o_ball_y      = r_o_y;
    assign o_vel_x       = r_o_vx;
    assign o_vel_y       = r_o_vy;
    assign o_bounce_mask = r_o_mask;

endmodule
`default_nettype wire

// ===== hw/rtl/ball_bounce_step_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ball_bounce_step_top: one time tick of a bouncing ball
// Each input beat carries dt and a speed command; each output beat carries
// the new position, velocity and the mask of bounces that fired.
//
// Usage:
//   - Input stream s_axis: tdata = {pad, speed_cmd[1:0], dt[15:0]}.
//   - Output stream m_axis: tdata = {pad, mask, vel_y, vel_x, ball_y, ball_x}.
//   - Config port: write i_cfg_data into register i_cfg_idx while idle.
//   - A tick that changes speed also runs the square root, loads the root
//     and runs two 48-step divisions; a line bounce adds two more
//     divisions. The divider works one quotient bit per cycle.
//   - One tick is worked at a time; the next beat is taken in the cycle in
//     which the previous result first sits in the output register, even
//     if that result is not taken.
//   - Reset puts the ball at (400, 300) px with velocity (106, 106) px/s and
//     loads the default walls and line.
//   - When the receiver stalls, the result holds in the output register and
//     the following tick waits at its last step until the register is free.
// ----------------------------------------------------------------------------
module ball_bounce_step_top #(
    parameter int BALL_RADIUS = bbs_pkg::BBS_BALL_RADIUS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bbs_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // dt[15:0], speed_cmd[17:16], zero pad
    input  wire logic [bbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // ball_x[21:0], ball_y[43:22], vel_x[62:44], vel_y[81:63],
    // bounce_mask[86:82], zero pad
    output logic [bbs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import bbs_pkg::*;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [POS_W-1:0]  ball_x, ball_y;
    logic [VEL_W-1:0]  vel_x, vel_y;
    logic [MASK_W-1:0] mask;

    bbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bbs_dp #(
        .BALL_RADIUS (BALL_RADIUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_dt          (s_axis_tdata[DT_W-1:0]),
        .i_speed_cmd   (s_axis_tdata[DT_W+CMD_W-1:DT_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_ball_x      (ball_x),
        .o_ball_y      (ball_y),
        .o_vel_x       (vel_x),
        .o_vel_y       (vel_y),
        .o_bounce_mask (mask)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {1'b0, mask, vel_y, vel_x, ball_y, ball_x};

endmodule
`default_nettype wire

// ===== hw/rtl/bbs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_checker: port-level checks of the ball step
// Watches the streams of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bbs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata
);

    // a held result beat keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // after taking a beat the block is busy with it
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // a left bounce leaves the ball moving right
    a_left_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[84] |-> !m_axis_tdata[62])
        else $error("left bounce with negative x velocity");

    // a bottom bounce leaves the ball moving up
    a_bottom_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[86] |-> !m_axis_tdata[81])
        else $error("bottom bounce with negative y velocity");

endmodule

bind ball_bounce_step_top bbs_checker u_bbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/ball_bounce_step_top_tb.sv =====
// ----------------------------------------------------------------------------
// ball_bounce_step_top_tb: self-checking bench for the ball bounce step
// Drives tick beats (dt, speed command) with random gaps, keeps its own
// model of ball position, velocity and the wall/line setup, and compares
// every output beat field by field against the oldest predicted tick.
// ----------------------------------------------------------------------------
module ball_bounce_step_top_tb;
    import bbs_pkg::*;

    localparam int TICK_LAT = 300;   // worst tick latency plus margin
    localparam longint RAD  = 40 * 256;

    typedef struct {
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic [VEL_W-1:0] vx;
        logic [VEL_W-1:0] vy;
        logic [MASK_W-1:0] mask;
    } t_tick_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    ball_bounce_step_top dut (.*);

    always #4 i_clk = ~i_clk;

    // shadow state of the ball and the setup
    longint geo [CFG_N];
    longint px, py, vx, vy;

    logic [IN_TDATA_W-1:0] tick_q [$];
    t_tick_res want_q [$];
    int  n_err = 0;
    int  n_sent = 0;
    bit  flood = 0;       // driver sends back to back
    int  hold_rx = 0;     // receiver hold-off length requested

    function automatic longint clamp(longint v, int bits);
        longint hi = (longint'(1) << (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint rnd_div(longint n, longint d);
        return n >= 0 ? (n + d / 2) / d : -((-n + d / 2) / d);
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r = 0;
        longint b = longint'(1) << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // advance the shadow ball by one tick and return the expected beat
    function automatic t_tick_res step_ball(logic [15:0] dt_in, logic [1:0] cmd);
        t_tick_res res;
        longint dt = dt_in;
        longint s2, m, ddx, ddy, dx, dy, nn, sdist, vn, ad;
        bit go, near;
        logic [MASK_W-1:0] mk = '0;
        if (cmd == CMD_UP || cmd == CMD_DOWN) begin
            s2 = vx * vx + vy * vy;
            go = (cmd == CMD_UP) ? (s2 < 64'd16384000000) : (s2 > 64'd6553600);
            m = int_sqrt(s2);
            if (go && m != 0) begin
                ddx = rnd_div(200 * dt * vx, m * 256);
                ddy = rnd_div(200 * dt * vy, m * 256);
                if (cmd == CMD_UP) begin
                    vx = clamp(vx + ddx, VEL_W);
                    vy = clamp(vy + ddy, VEL_W);
                end else begin
                    vx = clamp(vx - ddx, VEL_W);
                    vy = clamp(vy - ddy, VEL_W);
                end
            end
        end
        px = clamp(px + rnd_div(vx * dt, 65536), POS_W);
        py = clamp(py + rnd_div(vy * dt, 65536), POS_W);
        // line reflection
        dx = geo[CFG_LINE_B_X] - geo[CFG_LINE_A_X];
        dy = geo[CFG_LINE_B_Y] - geo[CFG_LINE_A_Y];
        nn = dx * dx + dy * dy;
        sdist = (px - geo[CFG_LINE_A_X] * 256) * dy - (py - geo[CFG_LINE_A_Y] * 256) * dx;
        vn = vx * dy - vy * dx;
        ad = sdist < 0 ? -sdist : sdist;
        near = (ad < (longint'(1) << 30)) && (ad * ad <= RAD * RAD * nn);
        if (nn != 0 && near && vn < 0) begin
            vx = clamp(vx - rnd_div(2 * vn * dy, nn), VEL_W);
            vy = clamp(vy + rnd_div(2 * vn * dx, nn), VEL_W);
            mk[0] = 1'b1;
        end
        // walls, each seeing the velocity left by the one before
        if (px + RAD >= geo[CFG_AREA_RIGHT] * 256 && vx > 0) begin
            vx = clamp(-vx, VEL_W); mk[1] = 1'b1;
        end
        if (px - RAD <= geo[CFG_AREA_LEFT] * 256 && vx < 0) begin
            vx = clamp(-vx, VEL_W); mk[2] = 1'b1;
        end
        if (py + RAD >= geo[CFG_AREA_TOP] * 256 && vy > 0) begin
            vy = clamp(-vy, VEL_W); mk[3] = 1'b1;
        end
        if (py - RAD <= geo[CFG_AREA_BOTTOM] * 256 && vy < 0) begin
            vy = clamp(-vy, VEL_W); mk[4] = 1'b1;
        end
        res.bx = px[POS_W-1:0];
        res.by = py[POS_W-1:0];
        res.vx = vx[VEL_W-1:0];
        res.vy = vy[VEL_W-1:0];
        res.mask = mk;
        return res;
    endfunction

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        return r < 55 ? 0 : (r < 92 ? $urandom_range(1, 4) : $urandom_range(10, 60));
    endfunction

    // capture tready at the rising edge to pair with tvalid
    logic s_axis_tready_q = 1'b0;
    always @(posedge i_clk) s_axis_tready_q <= i_rst_n && s_axis_tvalid && s_axis_tready;

    // driver: offer queued ticks, predict on each accepted beat
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready_q) begin
            want_q.push_back(step_ball(s_axis_tdata[15:0], s_axis_tdata[17:16]));
            n_sent++;
        end
        if (!s_axis_tvalid || s_axis_tready_q) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                s_axis_tdata <= tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                tx_gap = flood ? 0 : gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_tick_res w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (want_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected output beat %h", m_axis_tdata);
            end else begin
                w = want_q.pop_front();
                if (m_axis_tdata[21:0] !== w.bx || m_axis_tdata[43:22] !== w.by ||
                    m_axis_tdata[62:44] !== w.vx || m_axis_tdata[81:63] !== w.vy ||
                    m_axis_tdata[86:82] !== w.mask) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: want x=%h y=%h vx=%h vy=%h m=%h got %h",
                                 w.bx, w.by, w.vx, w.vy, w.mask, m_axis_tdata);
                end
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (hold_rx > 0) begin
            hold_rx--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!flood) rx_gap = gap_len();
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        geo[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || s_axis_tvalid || want_q.size() > 0) @(negedge i_clk);
        repeat (TICK_LAT) @(negedge i_clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] rand_tick(bit slow);
        logic [15:0] dt;
        dt = slow ? 16'($urandom) : 16'($urandom_range(0, 3000));
        return {6'd0, 2'($urandom_range(0, 3)), dt};
    endfunction

    initial begin
        logic [IN_TDATA_W-1:0] t;
        for (int i = 0; i < CFG_N; i++) geo[i] = CFG_RESET[i];
        px = 102400; py = 76800; vx = 27136; vy = 27136;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: dt extremes, every command, unused command
        tick_q.push_back({6'd0, 2'd0, 16'h0000});
        tick_q.push_back({6'd0, 2'd1, 16'hFFFF});
        tick_q.push_back({6'd0, 2'd2, 16'hFFFF});
        tick_q.push_back({6'd0, 2'd3, 16'h8000});
        for (int i = 0; i < 16; i++) tick_q.push_back({6'd0, 2'd1, 16'hFFFF});
        for (int i = 0; i < 4; i++) tick_q.push_back({6'd0, 2'(i), 16'h5555});
        drain();

        // random phases through several setups, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                1: begin   // degenerate line, full-range area
                    cfg_write(CFG_LINE_A_X, 12'd300); cfg_write(CFG_LINE_B_X, 12'd300);
                    cfg_write(CFG_LINE_A_Y, 12'd300); cfg_write(CFG_LINE_B_Y, 12'd300);
                    cfg_write(CFG_AREA_LEFT, 12'd0);  cfg_write(CFG_AREA_RIGHT, 12'hFFF);
                    cfg_write(CFG_AREA_BOTTOM, 12'd0); cfg_write(CFG_AREA_TOP, 12'hFFF);
                end
                2: begin   // small box, steep line through it
                    cfg_write(CFG_AREA_LEFT, 12'd100); cfg_write(CFG_AREA_RIGHT, 12'd500);
                    cfg_write(CFG_AREA_BOTTOM, 12'd100); cfg_write(CFG_AREA_TOP, 12'd500);
                    cfg_write(CFG_LINE_A_X, 12'd300); cfg_write(CFG_LINE_A_Y, 12'hFFF);
                    cfg_write(CFG_LINE_B_X, 12'd0);   cfg_write(CFG_LINE_B_Y, 12'd0);
                end
                3, 5: for (int r = 0; r < CFG_N; r++)
                    cfg_write(t_cfg_idx'(r), 12'($urandom));
                4: begin   // back to defaults
                    for (int r = 0; r < CFG_N; r++) cfg_write(t_cfg_idx'(r), CFG_RESET[r]);
                end
                6: begin   // inverted walls and extreme line
                    cfg_write(CFG_AREA_LEFT, 12'hFFF); cfg_write(CFG_AREA_RIGHT, 12'd0);
                    cfg_write(CFG_LINE_A_X, 12'd0);  cfg_write(CFG_LINE_B_X, 12'hFFF);
                end
                default: ;
            endcase
            for (int i = 0; i < 240; i++) tick_q.push_back(rand_tick($urandom_range(0, 9) == 0));
            if (ph == 2) begin
                // flood input while the receiver holds off
                flood = 1;
                hold_rx = 800;
                while (hold_rx > 0) @(negedge i_clk);
                flood = 0;
            end
            drain();
        end

        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end
endmodule
